>>> design/ptz_frm_pkg.sv
// ptz_frm_pkg: sizes, types and codes shared by the serial frame receiver
// no dependencies; every other design file refers to it by scoped names
`default_nettype none

package ptz_frm_pkg;

    localparam int FRAME_BYTES  = 8;
    localparam int BUFFER_BYTES = 32;
    localparam int QUEUE_DEPTH  = 8;
    localparam int CMDQ_DEPTH   = 2;

    localparam int BYTE_W      = 8;
    localparam int WORD_W      = 16;
    localparam int ACTION_BITS = 10;
    localparam int ACTION_LSB  = 1;

    localparam int POS_W     = $clog2(BUFFER_BYTES);
    localparam int FIDX_W    = $clog2(FRAME_BYTES);
    localparam int QPTR_W    = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int CQ_PTR_W  = $clog2(CMDQ_DEPTH);
    localparam int CQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = BYTE_W;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [WORD_W-1:0] t_word;
    typedef t_byte [FRAME_BYTES-1:0] t_frame;

    localparam t_byte START_BYTE_RST = 8'hA0;
    localparam t_byte END_BYTE_RST   = 8'hAF;

    typedef enum logic [0:0] {
        OP_BYTE = 1'b0,
        OP_PULL = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_BYTE = 1'b0,
        REG_END_BYTE   = 1'b1
    } t_reg_idx;

    typedef struct packed {
        t_op   op;
        t_byte data;
    } t_cmd;

    typedef struct packed {
        t_byte start_byte;
        t_byte end_byte;
    } t_cfg;

    typedef struct packed {
        logic   valid;
        logic   present;
        t_frame frame;
    } t_pop;

endpackage

`default_nettype wire

>>> design/ptz_frm_in_if.sv
// ptz_frm_in_if: input channel carrying a received byte or a pull request
// depends on ptz_frm_pkg
`default_nettype none

interface ptz_frm_in_if;
    logic                valid;
    logic                ready;
    logic                action;
    ptz_frm_pkg::t_byte  rx_byte;

    modport source (output valid, output action, output rx_byte, input ready);
    modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

`default_nettype wire

>>> design/ptz_frm_out_if.sv
// ptz_frm_out_if: result channel carrying one result beat per pull, decoded from a frame when one is present
// depends on ptz_frm_pkg
`default_nettype none

interface ptz_frm_out_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   message_present;
    logic                                   frame_ok;
    ptz_frm_pkg::t_byte                     camera_address;
    ptz_frm_pkg::t_word                     command_word;
    ptz_frm_pkg::t_word                     data_word;
    logic                                   stop_request;
    logic [ptz_frm_pkg::ACTION_BITS-1:0]    command_actions;

    modport source (output valid, output message_present, output frame_ok,
                    output camera_address, output command_word, output data_word,
                    output stop_request, output command_actions, input ready);
    modport sink   (input valid, input message_present, input frame_ok,
                    input camera_address, input command_word, input data_word,
                    input stop_request, input command_actions, output ready);
endinterface

`default_nettype wire

>>> design/ptz_serial_frame_receiver_core.sv
// ptz_serial_frame_receiver_core: top level of the serial frame receiver
// depends on ptz_frm_pkg, both channel interfaces, front, exec and check modules
//
// channel    direction  beat contents
// i_in       in         action, rx_byte
// o_out      out        message_present, frame_ok, camera_address, command_word,
//                       data_word, stop_request, command_actions
// i_cfg_*    in         write enable, register index, 8-bit data
//
// one beat accepted per cycle, bytes and pulls alike, while the command queue has room
// a pull beat's result is registered in the queue, the fifo read and the check stage
// byte beats yield nothing; a completed frame enters a non-full fifo for the next beat
// a stalled result holds later pulls and, in order, any bytes queued behind them
// reset empties queues, no clearing pass; unwritten frame data is masked by present
`default_nettype none

module ptz_serial_frame_receiver_core (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    ptz_frm_in_if.sink                                  i_in,
    ptz_frm_out_if.source                               o_out,
    input  wire logic                                   i_cfg_we,
    input  wire logic [ptz_frm_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [ptz_frm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    ptz_frm_pkg::t_cfg  r_cfg;
    logic               w_cmd_valid;
    ptz_frm_pkg::t_cmd  w_cmd;
    logic               w_cmd_ready;
    ptz_frm_pkg::t_pop  w_pop;
    logic               w_pop_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte <= ptz_frm_pkg::START_BYTE_RST;
            r_cfg.end_byte   <= ptz_frm_pkg::END_BYTE_RST;
        end else if (i_cfg_we) begin
            case (ptz_frm_pkg::t_reg_idx'(i_cfg_idx))
                ptz_frm_pkg::REG_START_BYTE: r_cfg.start_byte <= i_cfg_data;
                ptz_frm_pkg::REG_END_BYTE:   r_cfg.end_byte   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    ptz_frm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_ready (w_cmd_ready)
    );

    ptz_frm_exec u_exec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_ready (w_cmd_ready),
        .i_cfg       (r_cfg),
        .o_pop       (w_pop),
        .i_pop_take  (w_pop_take)
    );

    ptz_frm_check u_check (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_pop   (w_pop),
        .o_take  (w_pop_take),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

>>> design/ptz_frm_front.sv
// ptz_frm_front: accepts input beats, classifies them and queues commands
// depends on ptz_frm_pkg and ptz_frm_in_if
`default_nettype none

module ptz_frm_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    ptz_frm_in_if.sink              i_in,
    output      logic               o_cmd_valid,
    output      ptz_frm_pkg::t_cmd  o_cmd,
    input  wire logic               i_cmd_ready
);

    ptz_frm_pkg::t_cmd                      r_q [ptz_frm_pkg::CMDQ_DEPTH];
    logic [ptz_frm_pkg::CQ_PTR_W-1:0]       r_wp, n_wp;
    logic [ptz_frm_pkg::CQ_PTR_W-1:0]       r_rp, n_rp;
    logic [ptz_frm_pkg::CQ_CNT_W-1:0]       r_cnt, n_cnt;
    ptz_frm_pkg::t_cmd                      w_cmd;
    logic                                   w_push;
    logic                                   w_pop;

    always_comb begin
        w_cmd.data = i_in.rx_byte;
        case (ptz_frm_pkg::t_op'(i_in.action))
            ptz_frm_pkg::OP_PULL: w_cmd.op = ptz_frm_pkg::OP_PULL;
            default:              w_cmd.op = ptz_frm_pkg::OP_BYTE;
        endcase
    end

    assign i_in.ready  = (r_cnt < ptz_frm_pkg::CQ_CNT_W'(ptz_frm_pkg::CMDQ_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];
    assign w_push      = i_in.valid && i_in.ready;
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        if (w_push) begin
            n_wp = (r_wp == ptz_frm_pkg::CQ_PTR_W'(ptz_frm_pkg::CMDQ_DEPTH - 1))
                   ? '0 : r_wp + 1'b1;
        end
        if (w_pop) begin
            n_rp = (r_rp == ptz_frm_pkg::CQ_PTR_W'(ptz_frm_pkg::CMDQ_DEPTH - 1))
                   ? '0 : r_rp + 1'b1;
        end
        n_cnt = r_cnt + ptz_frm_pkg::CQ_CNT_W'(w_push) - ptz_frm_pkg::CQ_CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

>>> design/ptz_frm_exec.sv
// ptz_frm_exec: frame assembly, message fifo and pop stage
// depends on ptz_frm_pkg
`default_nettype none

module ptz_frm_exec (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cmd_valid,
    input  wire ptz_frm_pkg::t_cmd  i_cmd,
    output      logic               o_cmd_ready,
    input  wire ptz_frm_pkg::t_cfg  i_cfg,
    output      ptz_frm_pkg::t_pop  o_pop,
    input  wire logic               i_pop_take
);

    ptz_frm_pkg::t_frame                r_frame;
    ptz_frm_pkg::t_frame                r_mem [ptz_frm_pkg::QUEUE_DEPTH];
    ptz_frm_pkg::t_frame                r_pop_frame;
    logic                               r_pop_valid;
    logic                               r_pop_present;
    logic [ptz_frm_pkg::POS_W-1:0]      r_pos, n_pos;
    logic [ptz_frm_pkg::QPTR_W-1:0]     r_wr_ptr, n_wr_ptr;
    logic [ptz_frm_pkg::QPTR_W-1:0]     r_rd_ptr, n_rd_ptr;
    logic [ptz_frm_pkg::QCNT_W-1:0]     r_count, n_count;

    logic                               w_pop_free;
    logic                               w_is_byte;
    logic                               w_is_pull;
    logic [ptz_frm_pkg::POS_W-1:0]      w_pos_eff;
    logic                               w_wr_frame;
    logic                               w_frame_done;
    logic                               w_push;
    logic                               w_pop;
    ptz_frm_pkg::t_frame                w_push_frame;

    assign w_pop_free  = !r_pop_valid || i_pop_take;
    assign o_cmd_ready = (i_cmd.op == ptz_frm_pkg::OP_BYTE) || w_pop_free;
    assign w_is_byte   = i_cmd_valid && o_cmd_ready && (i_cmd.op == ptz_frm_pkg::OP_BYTE);
    assign w_is_pull   = i_cmd_valid && o_cmd_ready && (i_cmd.op == ptz_frm_pkg::OP_PULL);

    always_comb begin
        w_pos_eff    = (i_cmd.data == i_cfg.start_byte) ? '0 : r_pos;
        w_wr_frame   = w_is_byte && (w_pos_eff < ptz_frm_pkg::POS_W'(ptz_frm_pkg::FRAME_BYTES));
        n_pos        = r_pos;
        if (w_is_byte) begin
            n_pos = (w_pos_eff == ptz_frm_pkg::POS_W'(ptz_frm_pkg::BUFFER_BYTES - 1))
                    ? '0 : w_pos_eff + 1'b1;
        end
        w_frame_done = w_is_byte && (n_pos == ptz_frm_pkg::POS_W'(ptz_frm_pkg::FRAME_BYTES));
        w_push       = w_frame_done &&
                       (r_count != ptz_frm_pkg::QCNT_W'(ptz_frm_pkg::QUEUE_DEPTH));
        w_pop        = w_is_pull && (r_count != '0);

        w_push_frame = r_frame;
        w_push_frame[ptz_frm_pkg::FRAME_BYTES-1] = i_cmd.data;

        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == ptz_frm_pkg::QPTR_W'(ptz_frm_pkg::QUEUE_DEPTH - 1))
                       ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == ptz_frm_pkg::QPTR_W'(ptz_frm_pkg::QUEUE_DEPTH - 1))
                       ? '0 : r_rd_ptr + 1'b1;
        end
        n_count = r_count + ptz_frm_pkg::QCNT_W'(w_push) - ptz_frm_pkg::QCNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_frame) begin
            r_frame[w_pos_eff[ptz_frm_pkg::FIDX_W-1:0]] <= i_cmd.data;
        end
    end

    // message fifo storage, registered read
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_push_frame;
        end
        if (w_is_pull) begin
            r_pop_frame <= r_mem[r_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos         <= '0;
            r_wr_ptr      <= '0;
            r_rd_ptr      <= '0;
            r_count       <= '0;
            r_pop_valid   <= 1'b0;
            r_pop_present <= 1'b0;
        end else begin
            r_pos    <= n_pos;
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
            if (w_is_pull) begin
                r_pop_valid   <= 1'b1;
                r_pop_present <= w_pop;
            end else if (i_pop_take) begin
                r_pop_valid   <= 1'b0;
            end
        end
    end

    assign o_pop.valid   = r_pop_valid;
    assign o_pop.present = r_pop_present;
    assign o_pop.frame   = r_pop_frame;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ptz_frm_pkg::QCNT_W'(ptz_frm_pkg::QUEUE_DEPTH))
        else $error("message fifo count out of range");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == ptz_frm_pkg::QCNT_W'(ptz_frm_pkg::QUEUE_DEPTH))
        |-> (r_wr_ptr == r_rd_ptr))
        else $error("fifo pointers disagree with count");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos < ptz_frm_pkg::POS_W'(ptz_frm_pkg::BUFFER_BYTES - 1) ||
        r_pos == ptz_frm_pkg::POS_W'(ptz_frm_pkg::BUFFER_BYTES - 1))
        else $error("byte position beyond buffer");

    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_frame_done && r_count == ptz_frm_pkg::QCNT_W'(ptz_frm_pkg::QUEUE_DEPTH))
        |=> $stable(r_wr_ptr))
        else $error("push into a full fifo");

    a_pop_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pop_valid && !i_pop_take) |=> (r_pop_valid && $stable(r_pop_present)))
        else $error("pop stage lost a beat");

endmodule

`default_nettype wire

>>> design/ptz_frm_check.sv
// ptz_frm_check: validates a popped frame, decodes fields, holds the result beat
// depends on ptz_frm_pkg and ptz_frm_out_if
`default_nettype none

module ptz_frm_check (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire ptz_frm_pkg::t_cfg  i_cfg,
    input  wire ptz_frm_pkg::t_pop  i_pop,
    output      logic               o_take,
    ptz_frm_out_if.source           o_out
);

    logic                                   r_valid;
    logic                                   r_present;
    logic                                   r_ok;
    ptz_frm_pkg::t_byte                     r_addr;
    ptz_frm_pkg::t_word                     r_comm;
    ptz_frm_pkg::t_word                     r_data;
    logic                                   r_stop;
    logic [ptz_frm_pkg::ACTION_BITS-1:0]    r_actions;

    ptz_frm_pkg::t_byte                     w_sum;
    logic                                   w_ok;
    ptz_frm_pkg::t_byte                     w_addr;
    ptz_frm_pkg::t_word                     w_comm;
    ptz_frm_pkg::t_word                     w_data;

    assign o_take = i_pop.valid && (!r_valid || o_out.ready);

    always_comb begin
        w_sum = '0;
        for (int i = 1; i < ptz_frm_pkg::FRAME_BYTES - 2; i++) begin
            w_sum = w_sum ^ i_pop.frame[ptz_frm_pkg::FIDX_W'(i)];
        end
        w_ok   = i_pop.present &&
                 (i_pop.frame[0] == i_cfg.start_byte) &&
                 (i_pop.frame[ptz_frm_pkg::FRAME_BYTES-2] == i_cfg.end_byte) &&
                 (i_pop.frame[ptz_frm_pkg::FRAME_BYTES-1] == w_sum);
        w_addr = i_pop.present ? i_pop.frame[1] : '0;
        w_comm = i_pop.present ? {i_pop.frame[2], i_pop.frame[3]} : '0;
        w_data = i_pop.present ? {i_pop.frame[4], i_pop.frame[5]} : '0;
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_present <= i_pop.present;
            r_ok      <= w_ok;
            r_addr    <= w_addr;
            r_comm    <= w_comm;
            r_data    <= w_data;
            r_stop    <= w_ok && (w_comm == '0) && (w_data == '0);
            r_actions <= w_ok ? w_comm[ptz_frm_pkg::ACTION_LSB +: ptz_frm_pkg::ACTION_BITS]
                              : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_out.valid           = r_valid;
    assign o_out.message_present = r_present;
    assign o_out.frame_ok        = r_ok;
    assign o_out.camera_address  = r_addr;
    assign o_out.command_word    = r_comm;
    assign o_out.data_word       = r_data;
    assign o_out.stop_request    = r_stop;
    assign o_out.command_actions = r_actions;

endmodule

`default_nettype wire
